[rtl/cbd_pkg.sv]
// Shared types and codes for the chunked body decoder.
package cbd_pkg;

	localparam int unsigned CHUNK_W = 24;
	localparam int unsigned BODY_W  = 32;
	localparam int unsigned ACC_W   = 28;

	localparam logic [CHUNK_W-1:0] MAX_CHUNK_RESET = 24'd65536;
	localparam logic [BODY_W-1:0]  MAX_BODY_RESET  = 32'd1048576;

	// configuration register indexes
	localparam logic CFG_MAX_CHUNK = 1'b0;
	localparam logic CFG_MAX_BODY  = 1'b1;

	// input commands
	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_EOS     = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	// decoder phases
	localparam logic [2:0] PH_SIZE_START  = 3'd0;
	localparam logic [2:0] PH_SIZE_DIGITS = 3'd1;
	localparam logic [2:0] PH_SIZE_CR     = 3'd2;
	localparam logic [2:0] PH_DATA        = 3'd3;
	localparam logic [2:0] PH_TRAIL_START = 3'd4;
	localparam logic [2:0] PH_TRAIL_CR    = 3'd5;
	localparam logic [2:0] PH_DONE        = 3'd6;
	localparam logic [2:0] PH_ERROR       = 3'd7;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_byte;
	} cbd_in_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        body_byte;
		logic [BODY_W-1:0] body_length;
	} cbd_out_t;

	typedef struct packed {
		logic [2:0]         phase;
		logic [ACC_W-1:0]   size_acc;
		logic [CHUNK_W-1:0] bytes_left;
		logic [BODY_W-1:0]  body_count;
	} cbd_state_t;

endpackage

[rtl/cbd_step.sv]
// Next-state and result logic for one connection byte or command.
module cbd_step (
	input  cbd_pkg::cbd_state_t              st,
	input  cbd_pkg::cbd_in_t                 item,
	input  logic [cbd_pkg::CHUNK_W-1:0]      max_chunk_size,
	input  logic [cbd_pkg::BODY_W-1:0]       max_body_size,
	output cbd_pkg::cbd_state_t              nxt,
	output logic                             emit,
	output cbd_pkg::cbd_out_t                res
);

	logic                          is_hex;
	logic [3:0]                    hex_val;
	logic [cbd_pkg::ACC_W-1:0]     acc_shift;
	logic [cbd_pkg::BODY_W:0]      body_sum;
	logic                          body_over;
	logic [7:0]                    c;

	assign c = item.in_byte;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			hex_val = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			hex_val = c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign acc_shift = {st.size_acc[cbd_pkg::ACC_W-5:0], hex_val};
	assign body_sum  = {1'b0, st.body_count}
		+ {{(cbd_pkg::BODY_W + 1 - cbd_pkg::ACC_W){1'b0}}, st.size_acc};
	assign body_over = body_sum > {1'b0, max_body_size};

	always_comb begin
		nxt      = st;
		emit     = 1'b0;
		res.kind = cbd_pkg::KIND_DATA;
		res.body_byte = 8'd0;

		if (item.cmd == cbd_pkg::CMD_RESTART) begin
			nxt = '0;
			nxt.phase = cbd_pkg::PH_SIZE_START;
		end else if (item.cmd == cbd_pkg::CMD_NOP || st.phase == cbd_pkg::PH_DONE
			|| st.phase == cbd_pkg::PH_ERROR) begin
			nxt = st;
		end else if (item.cmd == cbd_pkg::CMD_EOS) begin
			nxt.phase = cbd_pkg::PH_ERROR;
			emit      = 1'b1;
			res.kind  = cbd_pkg::KIND_ERROR;
		end else begin
			case (st.phase)
				cbd_pkg::PH_SIZE_START, cbd_pkg::PH_SIZE_DIGITS,
				cbd_pkg::PH_SIZE_CR: begin
					if (c == cbd_pkg::CHAR_LF) begin
						// end of size line
						if (st.size_acc == '0) begin
							nxt.phase = cbd_pkg::PH_DONE;
							emit      = 1'b1;
							res.kind  = cbd_pkg::KIND_COMPLETE;
						end else if (body_over) begin
							nxt.phase = cbd_pkg::PH_ERROR;
							emit      = 1'b1;
							res.kind  = cbd_pkg::KIND_ERROR;
						end else begin
							nxt.bytes_left = st.size_acc[cbd_pkg::CHUNK_W-1:0];
							nxt.size_acc   = '0;
							nxt.phase      = cbd_pkg::PH_DATA;
						end
					end else if (st.phase == cbd_pkg::PH_SIZE_CR) begin
						nxt.phase = cbd_pkg::PH_ERROR;
						emit      = 1'b1;
						res.kind  = cbd_pkg::KIND_ERROR;
					end else if (c == cbd_pkg::CHAR_CR) begin
						nxt.phase = cbd_pkg::PH_SIZE_CR;
					end else if (!is_hex) begin
						nxt.phase = cbd_pkg::PH_ERROR;
						emit      = 1'b1;
						res.kind  = cbd_pkg::KIND_ERROR;
					end else begin
						nxt.size_acc = acc_shift;
						if (acc_shift > {{(cbd_pkg::ACC_W - cbd_pkg::CHUNK_W){1'b0}},
							max_chunk_size}) begin
							nxt.phase = cbd_pkg::PH_ERROR;
							emit      = 1'b1;
							res.kind  = cbd_pkg::KIND_ERROR;
						end else begin
							nxt.phase = cbd_pkg::PH_SIZE_DIGITS;
						end
					end
				end
				cbd_pkg::PH_DATA: begin
					nxt.body_count = st.body_count + 1'b1;
					if (st.bytes_left != '0) begin
						nxt.bytes_left = st.bytes_left - 1'b1;
					end
					if (st.bytes_left <= {{(cbd_pkg::CHUNK_W-1){1'b0}}, 1'b1}) begin
						nxt.phase = cbd_pkg::PH_TRAIL_START;
					end
					emit          = 1'b1;
					res.kind      = cbd_pkg::KIND_DATA;
					res.body_byte = c;
				end
				cbd_pkg::PH_TRAIL_START, cbd_pkg::PH_TRAIL_CR: begin
					if (c == cbd_pkg::CHAR_LF) begin
						nxt.phase = cbd_pkg::PH_SIZE_START;
					end else if (c == cbd_pkg::CHAR_CR
						&& st.phase == cbd_pkg::PH_TRAIL_START) begin
						nxt.phase = cbd_pkg::PH_TRAIL_CR;
					end else begin
						nxt.phase = cbd_pkg::PH_ERROR;
						emit      = 1'b1;
						res.kind  = cbd_pkg::KIND_ERROR;
					end
				end
				default: begin
					nxt = st;
				end
			endcase
		end
		res.body_length = nxt.body_count;
	end

endmodule

[rtl/chunked_body_decoder_core.sv]
// Top level of the chunked body decoder: input stage, decoder state, result register.
//
// Decodes an HTTP/1.1 chunked body from the connection byte stream.
// in channel: one command per transfer (stream byte, end of stream, restart, no-op).
// out channel: at most one result per input transfer (data byte, body
// complete or error), in input order.
// cfg channel: index 0 writes max_chunk_size (low 24 bits of cfg_data),
// index 1 writes max_body_size; always ready, write only while idle.
// A transfer is taken into the input stage and then decoded into the result
// register once that register is empty or being read. Throughput is one byte
// per clock while the receiver keeps out_ready high, set by the single decode
// step between the input stage and the result register.
// When the receiver stalls the result register holds and the input stage
// fills; in_ready drops only once both are occupied.
// Reset clears the decoder to the start of a size line, body count zero,
// and loads the limit registers with 65536 and 1048576.
module chunked_body_decoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cbd_pkg::cbd_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cbd_pkg::cbd_out_t            out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [cbd_pkg::BODY_W-1:0]   cfg_data
);

	logic                          valid_s1;
	cbd_pkg::cbd_in_t              item_s1;
	logic                          adv_s1;
	cbd_pkg::cbd_state_t           state_q;
	cbd_pkg::cbd_state_t           state_nxt;
	logic                          step_emit;
	cbd_pkg::cbd_out_t             step_res;
	logic                          out_valid_q;
	cbd_pkg::cbd_out_t             out_data_q;
	logic [cbd_pkg::CHUNK_W-1:0]   max_chunk_q;
	logic [cbd_pkg::BODY_W-1:0]    max_body_q;

	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	cbd_step u_step (
		.st             (state_q),
		.item           (item_s1),
		.max_chunk_size (max_chunk_q),
		.max_body_size  (max_body_q),
		.nxt            (state_nxt),
		.emit           (step_emit),
		.res            (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= cbd_pkg::MAX_CHUNK_RESET;
			max_body_q  <= cbd_pkg::MAX_BODY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cbd_pkg::CFG_MAX_CHUNK) begin
				max_chunk_q <= cfg_data[cbd_pkg::CHUNK_W-1:0];
			end else begin
				max_body_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= {cbd_pkg::PH_SIZE_START,
				{(cbd_pkg::ACC_W + cbd_pkg::CHUNK_W + cbd_pkg::BODY_W){1'b0}}};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= step_emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_emit) begin
			out_data_q <= step_res;
		end
	end

	// a finished body stays silent until restart
	a_silent_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.cmd != cbd_pkg::CMD_RESTART
		&& (state_q.phase == cbd_pkg::PH_DONE || state_q.phase == cbd_pkg::PH_ERROR)
		|-> !step_emit)
		else $error("result produced after completion or error");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == cbd_pkg::PH_DATA |-> state_q.bytes_left != '0)
		else $error("data phase with no bytes left in chunk");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && step_emit && step_res.kind == cbd_pkg::KIND_DATA
		|=> state_q.body_count == $past(state_q.body_count) + 1'b1)
		else $error("body count did not advance on a data byte");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both stages are full");

endmodule

[tb/sv/tb_chunked_body_decoder_core.sv]
// Testbench for the chunked body decoder: stream driver, predictor, result checker.
module tb_chunked_body_decoder_core;

	localparam int QUIET_FROM = 800;
	localparam int QUIET_TO   = 1600;
	localparam int LONG_HOLD  = 80;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	cbd_pkg::cbd_in_t            in_data = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	cbd_pkg::cbd_out_t           out_data;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic                        cfg_index = 1'b0;
	logic [cbd_pkg::BODY_W-1:0]  cfg_data = '0;

	chunked_body_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state and its copy of the limit registers
	logic [2:0]                  dec_phase = cbd_pkg::PH_SIZE_START;
	logic [cbd_pkg::ACC_W-1:0]   dec_acc = '0;
	logic [cbd_pkg::CHUNK_W-1:0] dec_left = '0;
	logic [cbd_pkg::BODY_W-1:0]  dec_count = '0;
	logic [cbd_pkg::CHUNK_W-1:0] lim_chunk = cbd_pkg::MAX_CHUNK_RESET;
	logic [cbd_pkg::BODY_W-1:0]  lim_body = cbd_pkg::MAX_BODY_RESET;

	cbd_pkg::cbd_in_t  stream_q[$];	// items waiting for the driver
	cbd_pkg::cbd_in_t  frame_q[$];	// body under construction
	cbd_pkg::cbd_out_t decoded_q[$];	// predicted decoder results, oldest first

	int unsigned items_queued = 0;
	int unsigned accepted = 0;
	int unsigned seen = 0;
	int unsigned n_data = 0;
	int unsigned n_done = 0;
	int unsigned n_err = 0;
	int unsigned errs = 0;
	int unsigned cyc = 0;
	int unsigned hold_left = 0;
	bit          held_once = 1'b0;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic bit idle_now();
		if (cyc >= QUIET_FROM && cyc < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 12;
	endfunction

	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b0, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return {1'b0, 4'(c[3:0] + 4'd9)};
		return 5'h10;
	endfunction

	function automatic void post_result(logic [1:0] kind, logic [7:0] b);
		cbd_pkg::cbd_out_t r;
		r.kind = kind;
		r.body_byte = b;
		r.body_length = dec_count;
		decoded_q.push_back(r);
	endfunction

	function automatic void raise_error();
		dec_phase = cbd_pkg::PH_ERROR;
		post_result(cbd_pkg::KIND_ERROR, 8'h00);
	endfunction

	function automatic void close_size_line();
		logic [cbd_pkg::BODY_W:0] total;
		total = {1'b0, dec_count}
			+ {{(cbd_pkg::BODY_W + 1 - cbd_pkg::ACC_W){1'b0}}, dec_acc};
		if (dec_acc == '0) begin
			dec_phase = cbd_pkg::PH_DONE;
			post_result(cbd_pkg::KIND_COMPLETE, 8'h00);
		end else if (total > {1'b0, lim_body}) begin
			raise_error();
		end else begin
			dec_left = dec_acc[cbd_pkg::CHUNK_W-1:0];
			dec_acc = '0;
			dec_phase = cbd_pkg::PH_DATA;
		end
	endfunction

	function automatic void decode_item(cbd_pkg::cbd_in_t it);
		logic [4:0] nib;
		nib = hex_nibble(it.in_byte);
		if (it.cmd == cbd_pkg::CMD_RESTART) begin
			dec_phase = cbd_pkg::PH_SIZE_START;
			dec_acc = '0;
			dec_left = '0;
			dec_count = '0;
			return;
		end
		if (it.cmd == cbd_pkg::CMD_NOP || dec_phase == cbd_pkg::PH_DONE
			|| dec_phase == cbd_pkg::PH_ERROR)
			return;
		if (it.cmd == cbd_pkg::CMD_EOS) begin
			raise_error();
			return;
		end
		case (dec_phase)
		cbd_pkg::PH_SIZE_START, cbd_pkg::PH_SIZE_DIGITS: begin
			if (it.in_byte == cbd_pkg::CHAR_LF) begin
				close_size_line();
			end else if (it.in_byte == cbd_pkg::CHAR_CR) begin
				dec_phase = cbd_pkg::PH_SIZE_CR;
			end else if (nib[4]) begin
				raise_error();
			end else begin
				// size limit checked after every digit
				dec_acc = {dec_acc[cbd_pkg::ACC_W-5:0], nib[3:0]};
				if (dec_acc > {{(cbd_pkg::ACC_W - cbd_pkg::CHUNK_W){1'b0}}, lim_chunk})
					raise_error();
				else
					dec_phase = cbd_pkg::PH_SIZE_DIGITS;
			end
		end
		cbd_pkg::PH_SIZE_CR: begin
			if (it.in_byte == cbd_pkg::CHAR_LF)
				close_size_line();
			else
				raise_error();
		end
		cbd_pkg::PH_DATA: begin
			dec_count = dec_count + 1'b1;
			if (dec_left != '0)
				dec_left = dec_left - 1'b1;
			if (dec_left == '0)
				dec_phase = cbd_pkg::PH_TRAIL_START;
			post_result(cbd_pkg::KIND_DATA, it.in_byte);
		end
		cbd_pkg::PH_TRAIL_START: begin
			if (it.in_byte == cbd_pkg::CHAR_LF)
				dec_phase = cbd_pkg::PH_SIZE_START;
			else if (it.in_byte == cbd_pkg::CHAR_CR)
				dec_phase = cbd_pkg::PH_TRAIL_CR;
			else
				raise_error();
		end
		cbd_pkg::PH_TRAIL_CR: begin
			if (it.in_byte == cbd_pkg::CHAR_LF)
				dec_phase = cbd_pkg::PH_SIZE_START;
			else
				raise_error();
		end
		default: ;
		endcase
	endfunction

	// driver: one nonblocking update per signal per edge
	always @(posedge clk) begin : stream_driver
		bit take;
		take = in_valid && in_ready;
		if (arst_n) begin
			if (take) begin
				decode_item(in_data);
				accepted++;
			end
			if (!in_valid || take) begin
				if (stream_q.size() != 0 && !idle_now()) begin
					in_valid <= 1'b1;
					in_data <= stream_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer and paces out_ready
	always @(posedge clk) begin : result_monitor
		cbd_pkg::cbd_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen++;
				case (out_data.kind)
				cbd_pkg::KIND_DATA:     n_data++;
				cbd_pkg::KIND_COMPLETE: n_done++;
				default:                n_err++;
				endcase
				if (decoded_q.size() == 0) begin
					$error("result with nothing expected: kind %0d", out_data.kind);
					errs++;
				end else begin
					want = decoded_q.pop_front();
					if (out_data.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_data.kind);
						errs++;
					end
					if (out_data.body_byte !== want.body_byte) begin
						$error("body_byte: expected %0h, got %0h",
							want.body_byte, out_data.body_byte);
						errs++;
					end
					if (out_data.body_length !== want.body_length) begin
						$error("body_length: expected %0d, got %0d",
							want.body_length, out_data.body_length);
						errs++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!held_once && seen >= 150 && in_valid) begin
				// long stall with the sender still offering: input side must back up
				held_once <= 1'b1;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idle_now();
			end
		end
	end

	task automatic put_item(logic [1:0] cmd, logic [7:0] b);
		cbd_pkg::cbd_in_t it;
		it.cmd = cmd;
		it.in_byte = b;
		frame_q.push_back(it);
	endtask

	task automatic flush();
		while (frame_q.size() != 0) begin
			stream_q.push_back(frame_q.pop_front());
			items_queued++;
		end
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + {4'h0, n};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
	endfunction

	task automatic put_size(logic [cbd_pkg::ACC_W-1:0] sz);
		int nd;
		nd = 1;
		for (int k = 1; k < 7; k++)
			if (sz[4*k +: 4] != 4'h0)
				nd = k + 1;
		repeat ($urandom_range(0, 2)) put_item(cbd_pkg::CMD_BYTE, "0");
		for (int k = nd - 1; k >= 0; k--)
			put_item(cbd_pkg::CMD_BYTE, hex_char(sz[4*k +: 4]));
	endtask

	task automatic put_eol();
		if ($urandom_range(0, 1))
			put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_CR);
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
	endtask

	// one well-formed body with random content, sometimes broken on purpose
	task automatic gen_body();
		int unsigned nch, sz, pos, mode;
		bit over;
		cbd_pkg::cbd_in_t nop;
		logic [cbd_pkg::ACC_W-1:0] size_v;
		logic [4:0] bump;
		over = 1'b0;
		nch = $urandom_range(0, 4);
		for (int k = 0; k < nch && !over; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				bump = 5'($urandom_range(1, 16));
				size_v = {{(cbd_pkg::ACC_W - cbd_pkg::CHUNK_W){1'b0}}, lim_chunk}
					+ {{(cbd_pkg::ACC_W - 5){1'b0}}, bump};
				put_size(size_v);
				put_eol();
				over = 1'b1;
			end else begin
				sz = $urandom_range(1, (lim_chunk < 24'd8) ? 32'(lim_chunk) : 32'd8);
				if (lim_chunk >= 24'd40 && $urandom_range(0, 9) == 0)
					sz = $urandom_range(9, 40);
				size_v = sz[cbd_pkg::ACC_W-1:0];
				put_size(size_v);
				put_eol();
				repeat (sz) put_item(cbd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
				put_eol();
			end
		end
		if (!over) begin
			if ($urandom_range(0, 2) != 0)
				put_size('0);
			put_eol();
		end
		pos = $urandom_range(0, frame_q.size() - 1);
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			frame_q[pos].in_byte = 8'($urandom_range(0, 255));
		end else if (mode < 18) begin
			// cut short, then end of stream or a restart mid-body
			while (frame_q.size() > pos)
				void'(frame_q.pop_back());
			if (mode < 14)
				put_item(cbd_pkg::CMD_EOS, 8'($urandom_range(0, 255)));
		end else if (mode < 22) begin
			nop.cmd = cbd_pkg::CMD_NOP;
			nop.in_byte = 8'($urandom_range(0, 255));
			frame_q.insert(pos, nop);
		end
		repeat ($urandom_range(0, 2))
			put_item(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		put_item(cbd_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
	endtask

	task automatic random_part(int unsigned n);
		int unsigned got;
		got = 0;
		while (got < n) begin
			if ($urandom_range(0, 99) < 10)
				repeat ($urandom_range(1, 6))
					put_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			else
				gen_body();
			got += frame_q.size();
			flush();
		end
	endtask

	// wait until every item is in and every result out, then let the pipe empty
	task automatic drain();
		do @(posedge clk);
		while (accepted != items_queued || decoded_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [cbd_pkg::BODY_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == cbd_pkg::CFG_MAX_CHUNK)
			lim_chunk = val[cbd_pkg::CHUNK_W-1:0];
		else
			lim_body = val;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// CRLF framing with extreme data bytes, then bytes after completion
		put_item(cbd_pkg::CMD_BYTE, "2");
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_CR);
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
		put_item(cbd_pkg::CMD_BYTE, 8'h00);
		put_item(cbd_pkg::CMD_BYTE, 8'hFF);
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_CR);
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
		put_item(cbd_pkg::CMD_BYTE, "0");
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
		put_item(cbd_pkg::CMD_BYTE, "x");
		put_item(cbd_pkg::CMD_EOS, 8'h00);
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		// chunk extension after a lowercase digit
		put_item(cbd_pkg::CMD_BYTE, "f");
		put_item(cbd_pkg::CMD_BYTE, ";");
		put_item(cbd_pkg::CMD_RESTART, 8'hFF);
		// empty size line completes at once
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		// lone CR
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_CR);
		put_item(cbd_pkg::CMD_BYTE, "x");
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		// no-op, then early end of stream
		put_item(cbd_pkg::CMD_NOP, 8'hFF);
		put_item(cbd_pkg::CMD_EOS, 8'hFF);
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		// size one past the chunk limit
		put_item(cbd_pkg::CMD_BYTE, "1");
		put_item(cbd_pkg::CMD_BYTE, "0");
		put_item(cbd_pkg::CMD_BYTE, "0");
		put_item(cbd_pkg::CMD_BYTE, "0");
		put_item(cbd_pkg::CMD_BYTE, "1");
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		// junk where the line end after data should be
		put_item(cbd_pkg::CMD_BYTE, "1");
		put_item(cbd_pkg::CMD_BYTE, cbd_pkg::CHAR_LF);
		put_item(cbd_pkg::CMD_BYTE, "z");
		put_item(cbd_pkg::CMD_BYTE, "z");
		put_item(cbd_pkg::CMD_RESTART, 8'h00);
		flush();
		drain();

		// upper data bits of the chunk limit write are dropped
		write_reg(cbd_pkg::CFG_MAX_CHUNK, 32'hA500_0010);
		write_reg(cbd_pkg::CFG_MAX_BODY, 32'd100);
		random_part(200);
		drain();

		write_reg(cbd_pkg::CFG_MAX_CHUNK, 32'h00FF_FFFF);
		write_reg(cbd_pkg::CFG_MAX_BODY, 32'hFFFF_FFFF);
		random_part(250);
		drain();

		write_reg(cbd_pkg::CFG_MAX_CHUNK, 32'd1);
		write_reg(cbd_pkg::CFG_MAX_BODY, 32'd1);
		random_part(150);
		drain();

		write_reg(cbd_pkg::CFG_MAX_CHUNK, $urandom_range(2, 40));
		write_reg(cbd_pkg::CFG_MAX_BODY, $urandom_range(20, 400));
		random_part(250);
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d input transfers and %0d results:", accepted, seen);
		$display("%0d data, %0d complete, %0d error; five limit settings, one long stall",
			n_data, n_done, n_err);
		if (errs == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: a time limit far beyond the slowest legal run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/cbd_pkg.sv
rtl/cbd_step.sv
rtl/chunked_body_decoder_core.sv
tb/sv/tb_chunked_body_decoder_core.sv
